// ----- hw/rtl/pclp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pclp_pkg;

	// Parse phase of the field being received.
	typedef enum logic [1:0] {
		PH_BLANKS,
		PH_NUMBER,
		PH_DONE
	} phase_t;

	// Target codes carried with each order word.
	typedef enum logic [2:0] {
		TGT_LED        = 3'd0,
		TGT_SCOPE_DEW  = 3'd1,
		TGT_FINDER_DEW = 3'd2,
		TGT_CAMERA     = 3'd3,
		TGT_SCOPE_CAP  = 3'd4,
		TGT_FINDER_CAP = 3'd5,
		TGT_UNKNOWN    = 3'd6
	} target_t;

	// Characters the parser reacts to.
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Fixed pin numbers of the known targets.
	localparam logic signed [15:0] PIN_SCOPE_DEW  = 16'sd11;
	localparam logic signed [15:0] PIN_FINDER_DEW = 16'sd4;
	localparam logic signed [15:0] PIN_CAMERA     = 16'sd5;
	localparam logic signed [15:0] PIN_SCOPE_CAP  = 16'sd9;
	localparam logic signed [15:0] PIN_FINDER_CAP = 16'sd10;

	// Saturation limits of a parsed field.
	localparam logic signed [15:0] FIELD_MAX = 16'sh7FFF;
	localparam logic signed [15:0] FIELD_MIN = -16'sh8000;

	// Reset value of the LED pin register.
	localparam logic [7:0] LED_PIN_RESET = 8'd13;

endpackage

`default_nettype wire

// ----- hw/rtl/pin_command_line_parser_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pin command line parser. Serial characters arrive on the rx channel, one word per byte, and
// form lines "pin,value" ended by a newline. Each field is parsed as a signed decimal number
// (leading blanks skipped, one optional sign, digits until the first other character),
// saturating at the 16-bit signed range. A newline that closes a complete line emits one order
// word with the pin, the value and a target code; the LED target follows the led_pin register
// written on the cfg channel (reset value 13), other pins map to fixed codes or to unknown.
// The block takes one byte per clock cycle at full rate; a byte passes an input register and
// the parse update, and an order word is registered in the order register as its newline
// leaves the input register. The one-deep order register sets the stall: input stalls only
// while an order waits and the byte in the input register cannot move on.
module pin_command_line_parser_unit
	import pclp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Received characters
	input  wire logic               rx_valid,
	output logic                    rx_ready,
	input  wire logic        [7:0]  rx_byte,
	// LED pin register write
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [7:0]  cfg_data,
	// Completed orders
	output logic                    order_valid,
	input  wire logic               order_ready,
	output logic signed      [15:0] order_pin,
	output logic signed      [15:0] order_value,
	output logic             [2:0]  target
);

	// Input stage
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance_s1;

	// Parser state
	phase_t            phase_q, phase_d;
	logic              neg_q, neg_d;
	logic signed [15:0] acc_q, acc_d;
	logic              nonempty_q, nonempty_d;
	logic              line_q, line_d;
	logic signed [15:0] pin_q, pin_d;
	logic signed [15:0] value_q, value_d;
	logic [7:0]        led_pin_q;

	// Output register
	logic              order_valid_q;
	logic signed [15:0] order_pin_q;
	logic signed [15:0] order_value_q;
	target_t           target_q;

	// Datapath signals
	logic              is_digit;
	logic              is_blank;
	logic              emit;
	logic [3:0]        digit;
	logic signed [20:0] acc_ext;
	logic signed [20:0] acc_x10;
	logic signed [20:0] acc_neg;
	logic signed [20:0] acc_pos;
	logic signed [15:0] acc_digit;
	target_t           target_d;

	// Handshakes: the input register moves on whenever the order slot is free or draining.
	assign advance_s1 = valid_s1 && (!order_valid_q || order_ready);
	assign rx_ready   = !valid_s1 || advance_s1;
	assign cfg_ready  = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Character classes.
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign is_blank = (byte_s1 == CHAR_SPACE) || ((byte_s1 >= CHAR_TAB) && (byte_s1 <= CHAR_CR));

	// Decimal accumulate with saturation on the side of the sign.
	assign digit   = byte_s1[3:0];
	assign acc_ext = 21'(acc_q);
	assign acc_x10 = (acc_ext <<< 3) + (acc_ext <<< 1);
	assign acc_neg = acc_x10 - $signed({17'd0, digit});
	assign acc_pos = acc_x10 + $signed({17'd0, digit});

	always_comb begin
		if (neg_q) begin
			acc_digit = (acc_neg < 21'(FIELD_MIN)) ? FIELD_MIN : acc_neg[15:0];
		end else begin
			acc_digit = (acc_pos > 21'(FIELD_MAX)) ? FIELD_MAX : acc_pos[15:0];
		end
	end

	// Target lookup of the stored pin; the LED pin takes priority.
	always_comb begin
		if (pin_q == $signed({8'd0, led_pin_q})) begin
			target_d = TGT_LED;
		end else begin
			case (pin_q)
				PIN_SCOPE_DEW:  target_d = TGT_SCOPE_DEW;
				PIN_FINDER_DEW: target_d = TGT_FINDER_DEW;
				PIN_CAMERA:     target_d = TGT_CAMERA;
				PIN_SCOPE_CAP:  target_d = TGT_SCOPE_CAP;
				PIN_FINDER_CAP: target_d = TGT_FINDER_CAP;
				default:        target_d = TGT_UNKNOWN;
			endcase
		end
	end

	// Next parser state for the byte in the input register.
	always_comb begin
		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		nonempty_d = nonempty_q;
		line_d     = line_q;
		pin_d      = pin_q;
		value_d    = value_q;
		emit       = 1'b0;
		if (byte_s1 == CHAR_NL) begin
			if (nonempty_q) begin
				value_d = acc_q;
				emit    = line_q;
			end
			line_d     = 1'b0;
			phase_d    = PH_BLANKS;
			neg_d      = 1'b0;
			acc_d      = '0;
			nonempty_d = 1'b0;
		end else if (byte_s1 == CHAR_COMMA) begin
			if (nonempty_q) begin
				pin_d  = acc_q;
				line_d = !line_q;
			end else begin
				line_d = 1'b0;
			end
			phase_d    = PH_BLANKS;
			neg_d      = 1'b0;
			acc_d      = '0;
			nonempty_d = 1'b0;
		end else begin
			nonempty_d = 1'b1;
			if (phase_q != PH_DONE) begin
				if (is_digit) begin
					acc_d   = acc_digit;
					phase_d = PH_NUMBER;
				end else if (phase_q == PH_BLANKS && is_blank) begin
					phase_d = PH_BLANKS;
				end else if (phase_q == PH_BLANKS &&
						(byte_s1 == CHAR_PLUS || byte_s1 == CHAR_MINUS)) begin
					neg_d   = (byte_s1 == CHAR_MINUS);
					phase_d = PH_NUMBER;
				end else begin
					phase_d = PH_DONE;
				end
			end
		end
	end

	// Parser state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_BLANKS;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			nonempty_q <= 1'b0;
			line_q     <= 1'b0;
			pin_q      <= '0;
			value_q    <= '0;
			led_pin_q  <= LED_PIN_RESET;
		end else begin
			if (advance_s1) begin
				phase_q    <= phase_d;
				neg_q      <= neg_d;
				acc_q      <= acc_d;
				nonempty_q <= nonempty_d;
				line_q     <= line_d;
				pin_q      <= pin_d;
				value_q    <= value_d;
			end
			if (cfg_valid && cfg_ready) begin
				led_pin_q <= cfg_data;
			end
		end
	end

	// Order register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			order_valid_q <= 1'b1;
		end else if (order_ready) begin
			order_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			order_pin_q   <= pin_q;
			order_value_q <= value_d;
			target_q      <= target_d;
		end
	end

	assign order_valid = order_valid_q;
	assign order_pin   = order_pin_q;
	assign order_value = order_value_q;
	assign target      = target_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pclp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks of the pin command line parser.
module pclp_checker
	import pclp_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rx_valid,
	input wire logic               rx_ready,
	input wire logic        [7:0]  rx_byte,
	input wire logic               order_valid,
	input wire logic               order_ready,
	input wire logic signed [15:0] order_pin,
	input wire logic        [2:0]  target
);

	// A stalled order word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		order_valid && !order_ready |=> order_valid)
		else $error("order word dropped while stalled");

	// A fresh order follows an accepted newline.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(order_valid) |-> $past(rx_valid && rx_ready && rx_byte == CHAR_NL, 2))
		else $error("order word without a newline");

	// The scope dew target only comes from its fixed pin.
	assert property (@(posedge clk) disable iff (!arst_n)
		order_valid && target == TGT_SCOPE_DEW |-> order_pin == PIN_SCOPE_DEW)
		else $error("scope dew target with wrong pin");

	// The LED target needs a pin inside the 8-bit register range.
	assert property (@(posedge clk) disable iff (!arst_n)
		order_valid && target == TGT_LED |-> order_pin[15:8] == 8'd0)
		else $error("LED target with out-of-range pin");

endmodule

bind pin_command_line_parser_unit pclp_checker u_pclp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx_valid),
	.rx_ready    (rx_ready),
	.rx_byte     (rx_byte),
	.order_valid (order_valid),
	.order_ready (order_ready),
	.order_pin   (order_pin),
	.target      (target)
);

`default_nettype wire
